// ----- src/fhpt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhpt_pkg
// shared types, constants and codes of the hashed position table
// ---------------------------------------------------------------------------
package fhpt_pkg;

  localparam int unsigned BUCKET_BITS_DEF = 10;
  localparam int unsigned WAYS            = 4;
  localparam int unsigned WORDS           = 4;
  localparam int unsigned COUNT_W         = 13;

  // splitmix64 finaliser
  localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [63:0]           pos_hash;
    logic [WORDS-1:0][63:0] black;
    logic [WORDS-1:0][63:0] white;
  } item_t;

  localparam int unsigned KEY_W = 64 + 2 * WORDS * 64;

  typedef struct packed {
    item_t       item;
    logic [63:0] mixed;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic               newly_filled;
    logic [COUNT_W-1:0] occupied_count;
  } res_t;

endpackage

// ----- src/fhpt_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhpt_queue
// two-entry first-in first-out buffer of words
// ---------------------------------------------------------------------------
module fhpt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= wr_data;
  end

endmodule

// ----- src/fhpt_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhpt_front
// three-stage hash mixer, 64-bit products built from 32-bit partials
// ---------------------------------------------------------------------------
module fhpt_front import fhpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  item_t  in_item,
  output logic   ready,
  output logic   out_valid,
  output entry_t out_entry,
  input  logic   out_full
);

  logic        adv;
  logic [63:0] v1;
  logic [63:0] prod1;
  logic [63:0] v2;
  logic [63:0] prod2;

  logic        a_valid;
  item_t       a_item;
  logic [63:0] a_p0;
  logic [31:0] a_p1;
  logic [31:0] a_p2;

  logic        b_valid;
  item_t       b_item;
  logic [63:0] b_p0;
  logic [31:0] b_p1;
  logic [31:0] b_p2;

  logic        c_valid;
  entry_t      c_entry;

  assign adv       = !c_valid || !out_full;
  assign ready     = adv;
  assign out_valid = c_valid;
  assign out_entry = c_entry;

  assign v1    = in_item.pos_hash ^ (in_item.pos_hash >> SHIFT_A);
  assign prod1 = a_p0 + {a_p1 + a_p2, 32'h0};
  assign v2    = prod1 ^ (prod1 >> SHIFT_B);
  assign prod2 = b_p0 + {b_p1 + b_p2, 32'h0};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= in_item;
      a_p0   <= {32'h0, v1[31:0]} * {32'h0, MIX_C1[31:0]};
      a_p1   <= v1[63:32] * MIX_C1[31:0];
      a_p2   <= v1[31:0] * MIX_C1[63:32];

      b_item <= a_item;
      b_p0   <= {32'h0, v2[31:0]} * {32'h0, MIX_C2[31:0]};
      b_p1   <= v2[63:32] * MIX_C2[31:0];
      b_p2   <= v2[31:0] * MIX_C2[63:32];

      c_entry.item  <= b_item;
      c_entry.mixed <= prod2 ^ (prod2 >> SHIFT_C);
    end
  end

endmodule

// ----- src/fhpt_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhpt_back
// bucket read, way compare and update; clears the tag store after reset
// ---------------------------------------------------------------------------
module fhpt_back import fhpt_pkg::*; #(
  parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  entry_t q_entry,
  output logic   q_pop,
  input  logic   res_full,
  output logic   res_push,
  output res_t   res,
  output logic   clearing
);

  localparam int unsigned BUCKETS = 1 << BUCKET_BITS;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [BUCKET_BITS-1:0] clr_idx;
  entry_t                 cur;
  logic [1:0]             victim;
  logic [1:0]             victim_next;
  logic [COUNT_W-1:0]     filled;
  logic [COUNT_W-1:0]     filled_next;

  logic [63:0]            cur_tag;
  logic [KEY_W-1:0]       cur_key;
  logic [BUCKET_BITS-1:0] cur_bucket;
  logic [BUCKET_BITS-1:0] rd_bucket;
  logic [BUCKET_BITS-1:0] wr_bucket;
  logic [63:0]            tag_wdata;

  logic [WAYS-1:0]        match;
  logic [WAYS-1:0]        vacant;
  logic [WAYS-1:0]        way_we;
  logic [1:0]             first;
  logic                   found;
  logic                   hit_v;
  logic                   fresh;

  assign clearing   = (state == ST_CLEAR);
  assign q_pop      = (state == ST_IDLE) && !q_empty && !res_full;
  assign cur_tag    = cur.mixed | 64'd1;
  assign cur_key    = {cur.item.pos_hash, cur.item.black, cur.item.white};
  assign cur_bucket = cur.mixed[BUCKET_BITS-1:0];
  assign rd_bucket  = q_entry.mixed[BUCKET_BITS-1:0];
  assign wr_bucket  = clearing ? clr_idx : cur_bucket;
  assign tag_wdata  = clearing ? 64'd0 : cur_tag;

  // one tag and one key memory per way, indexed by bucket
  for (genvar k = 0; k < WAYS; k++) begin : g_way
    logic [63:0]      tag_mem [BUCKETS];
    logic [KEY_W-1:0] key_mem [BUCKETS];
    logic [63:0]      tag_rd;
    logic [KEY_W-1:0] key_rd;

    always_ff @(posedge clk) begin
      if (clearing || way_we[k]) tag_mem[wr_bucket] <= tag_wdata;
      if (way_we[k]) key_mem[cur_bucket] <= cur_key;
      if (q_pop) begin
        tag_rd <= tag_mem[rd_bucket];
        key_rd <= key_mem[rd_bucket];
      end
    end

    assign match[k]  = (tag_rd == cur_tag) && (key_rd == cur_key);
    assign vacant[k] = (tag_rd == 64'd0);
  end

  // first way that either holds the key or is empty
  always_comb begin
    first = 2'd0;
    found = 1'b0;
    for (int k = 0; k < WAYS; k++) begin
      if (!found && (match[k] || vacant[k])) begin
        first = 2'(k);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    way_we      = '0;
    fresh       = 1'b0;
    hit_v       = 1'b0;
    victim_next = victim;
    if (state == ST_DECIDE) begin
      if (cur.item.op == OP_INSERT) begin
        if (found) begin
          if (match[first]) begin
            hit_v = 1'b1;
          end else begin
            way_we[first] = 1'b1;
            fresh         = 1'b1;
          end
        end else begin
          way_we[victim] = 1'b1;
          victim_next    = victim + 2'd1;
        end
      end else begin
        hit_v = |match;
      end
    end
  end

  assign filled_next        = filled + COUNT_W'(fresh);
  assign res_push           = (state == ST_DECIDE);
  assign res.hit            = hit_v;
  assign res.newly_filled   = fresh;
  assign res.occupied_count = filled_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == {BUCKET_BITS{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (q_pop) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      victim  <= 2'd0;
      filled  <= '0;
    end else begin
      state  <= state_next;
      victim <= victim_next;
      filled <= filled_next;
      if (clearing) clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
  end

endmodule

// ----- src/four_way_hashed_position_table_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_way_hashed_position_table_top
// 4-way set-associative table of seen positions with splitmix64 indexing
// ---------------------------------------------------------------------------
// path: three mixer stages, the middle queue, the bucket read and decide state, the result queue
// pacing: the back end takes no new word until it has read a bucket
//   and written it back before the next bucket read
// reset: synchronous; afterwards the tag store is swept one bucket a cycle,
//   over all 2^BUCKET_BITS buckets, with full held high until the sweep ends
// ---------------------------------------------------------------------------
module four_way_hashed_position_table_top import fhpt_pkg::*; #(
  parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input side, queue style
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [63:0]        pos_hash,
  input  logic [63:0]        black_word0,
  input  logic [63:0]        black_word1,
  input  logic [63:0]        black_word2,
  input  logic [63:0]        black_word3,
  input  logic [63:0]        white_word0,
  input  logic [63:0]        white_word1,
  input  logic [63:0]        white_word2,
  input  logic [63:0]        white_word3,
  // result side, queue style
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic               newly_filled,
  output logic [COUNT_W-1:0] occupied_count
);

  item_t  in_item;
  logic   accept;
  logic   front_ready;
  logic   front_valid;
  entry_t front_entry;
  logic   mid_full;
  logic   mid_empty;
  entry_t mid_entry;
  logic   mid_pop;
  logic   clearing;
  logic   res_push;
  logic   res_full;
  res_t   res_in;
  res_t   res_out;

  // gather the input word
  assign in_item.op       = opcode;
  assign in_item.pos_hash = pos_hash;
  assign in_item.black    = {black_word3, black_word2, black_word1, black_word0};
  assign in_item.white    = {white_word3, white_word2, white_word1, white_word0};

  // nothing enters while the tag store is being swept
  assign full   = !front_ready || clearing;
  assign accept = push && !full;

  // front end: hash mixing pipeline
  fhpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (in_item),
    .ready     (front_ready),
    .out_valid (front_valid),
    .out_entry (front_entry),
    .out_full  (mid_full)
  );

  // decoupling queue between mixer and table
  fhpt_queue #(
    .WIDTH ($bits(entry_t))
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .wr_data (front_entry),
    .pop     (mid_pop),
    .rd_data (mid_entry),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  // back end: bucket probe, fill or replace
  fhpt_back #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (mid_empty),
    .q_entry  (mid_entry),
    .q_pop    (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .clearing (clearing)
  );

  // result queue so that the table keeps working while a result waits
  fhpt_queue #(
    .WIDTH ($bits(res_t))
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .pop     (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign hit            = res_out.hit;
  assign newly_filled   = res_out.newly_filled;
  assign occupied_count = res_out.occupied_count;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the four-way hashed position table
// ---------------------------------------------------------------------------
// Lookups and inserts are driven through the queue-style input. Each accepted
// word is run through a shadow copy of the table, kept here, which gives the
// hit, fill and occupancy result that must come out next. Results are checked
// in order as they are popped. A directed opening covers the empty table,
// repeated keys, keys that share a tag but not a board, and a full bucket
// with round-robin replacement. Random words follow, crowded into a few
// buckets so that replacement is exercised often.
// ---------------------------------------------------------------------------
module tb;
  import fhpt_pkg::*;

  typedef logic [WORDS-1:0][63:0] words_t;

  localparam int unsigned TABLE_WAYS  = WAYS << BUCKET_BITS_DEF;
  localparam int unsigned BUCKETS     = 1 << BUCKET_BITS_DEF;
  localparam int          RANDOM_WORDS = 450;
  localparam int          IDLE_PCT    = 27;
  // stretch of words with no idling on either side
  localparam int          CALM_FROM   = 60;
  localparam int          CALM_TO     = 140;
  // long receiver hold-off, started once this many results have been taken
  localparam int          HOLD_AT     = 220;
  localparam int          HOLD_LEN    = 400;
  // the random word at this index waits until the table has drained
  localparam int          DRAIN_AT    = 320;
  // cycles with no handshake on either side; covers the clearing sweep and the hold-off
  localparam int          STALL_LIMIT = 6000;
  localparam int          TAIL_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               opcode = OP_LOOKUP;
  logic [63:0]        pos_hash = '0;
  logic [63:0]        black_word0 = '0;
  logic [63:0]        black_word1 = '0;
  logic [63:0]        black_word2 = '0;
  logic [63:0]        black_word3 = '0;
  logic [63:0]        white_word0 = '0;
  logic [63:0]        white_word1 = '0;
  logic [63:0]        white_word2 = '0;
  logic [63:0]        white_word3 = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               hit;
  logic               newly_filled;
  logic [COUNT_W-1:0] occupied_count;

  four_way_hashed_position_table_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .pos_hash       (pos_hash),
    .black_word0    (black_word0),
    .black_word1    (black_word1),
    .black_word2    (black_word2),
    .black_word3    (black_word3),
    .white_word0    (white_word0),
    .white_word1    (white_word1),
    .white_word2    (white_word2),
    .white_word3    (white_word3),
    .empty          (empty),
    .pop            (pop),
    .hit            (hit),
    .newly_filled   (newly_filled),
    .occupied_count (occupied_count)
  );

  // words still to be offered, and a flag per word asking for a full drain first
  item_t queued_probes[$];
  logic  drain_marks[$];
  // results owed by the table, oldest first
  res_t  pending_results[$];
  // keys already inserted, reused to provoke hits and near misses
  item_t inserted_keys[$];

  // shadow of the table contents
  logic [63:0]        shadow_tag   [TABLE_WAYS];
  logic [63:0]        shadow_hash  [TABLE_WAYS];
  words_t             shadow_black [TABLE_WAYS];
  words_t             shadow_white [TABLE_WAYS];
  logic [1:0]         shadow_victim;
  logic [COUNT_W-1:0] shadow_filled;

  int  errors_seen   = 0;
  int  probes_sent   = 0;
  int  results_taken = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  int  quiet_cycles  = 0;
  logic rx_holding;

  assign rx_holding = hold_left != 0;

  // splitmix64 finaliser
  function automatic logic [63:0] splitmix_mix(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> SHIFT_A);
    x = x * MIX_C1;
    x = x ^ (x >> SHIFT_B);
    x = x * MIX_C2;
    x = x ^ (x >> SHIFT_C);
    return x;
  endfunction

  // full key compare, only ever asked for a way whose tag matched
  function automatic logic way_holds(input int unsigned w, input item_t it);
    return shadow_hash[w] == it.pos_hash && shadow_black[w] == it.black &&
           shadow_white[w] == it.white;
  endfunction

  function automatic void store_way(input int unsigned w, input logic [63:0] tag,
                                    input item_t it);
    shadow_tag[w]   = tag;
    shadow_hash[w]  = it.pos_hash;
    shadow_black[w] = it.black;
    shadow_white[w] = it.white;
  endfunction

  // applies one word to the shadow table and returns the result it must give
  function automatic res_t probe_table(input item_t it);
    logic [63:0] mixed;
    logic [63:0] tag;
    int unsigned base;
    int unsigned w;
    logic        done;
    res_t        r;
    mixed = splitmix_mix(it.pos_hash);
    tag   = mixed | 64'd1;
    base  = int'(mixed[BUCKET_BITS_DEF-1:0]) * WAYS;
    r     = '0;
    done  = 1'b0;
    for (int k = 0; k < WAYS && !done; k++) begin
      w = base + k;
      if (shadow_tag[w] == tag && way_holds(w, it)) begin
        r.hit = 1'b1;
        done  = 1'b1;
      end else if (it.op == OP_INSERT && shadow_tag[w] == '0) begin
        store_way(w, tag, it);
        shadow_filled  = shadow_filled + 1'b1;
        r.newly_filled = 1'b1;
        done           = 1'b1;
      end
    end
    // bucket full and key absent: round-robin victim
    if (it.op == OP_INSERT && !done) begin
      store_way(base + shadow_victim, tag, it);
      shadow_victim = shadow_victim + 1'b1;
    end
    r.occupied_count = shadow_filled;
    return r;
  endfunction

  function automatic words_t random_words();
    words_t w;
    for (int k = 0; k < WORDS; k++) w[k] = {$urandom, $urandom};
    return w;
  endfunction

  // searches for a hash that lands in the given bucket
  function automatic logic [63:0] hash_for_bucket(input int unsigned b);
    logic [63:0] h;
    logic [63:0] m;
    do begin
      h = {$urandom, $urandom};
      m = splitmix_mix(h);
    end while (m[BUCKET_BITS_DEF-1:0] != b[BUCKET_BITS_DEF-1:0]);
    return h;
  endfunction

  function automatic item_t make_probe(input logic op, input logic [63:0] h,
                                       input words_t blk, input words_t wht);
    item_t it;
    it.op       = op;
    it.pos_hash = h;
    it.black    = blk;
    it.white    = wht;
    return it;
  endfunction

  function automatic void queue_probe(input item_t it, input logic drain_first);
    queued_probes = {queued_probes, it};
    drain_marks   = {drain_marks, drain_first};
    if (it.op == OP_INSERT) inserted_keys = {inserted_keys, it};
  endfunction

  // clock and the single reset at the start
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // input side: offers queued words, holds a word while full is high
  always @(posedge clk) begin : probe_driver
    logic taken;
    logic go;
    taken = push && !full;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (taken) begin
        queued_probes.delete(0);
        drain_marks.delete(0);
        probes_sent++;
      end
      if (!(push && !taken)) begin
        go = queued_probes.size() != 0;
        // keep offering during the hold-off so the table backs up
        if (go && !rx_holding && !(probes_sent >= CALM_FROM && probes_sent < CALM_TO))
          go = $urandom_range(99) >= IDLE_PCT;
        // a marked word waits until nothing is owed
        if (go && drain_marks[0] && (taken || pending_results.size() != 0))
          go = 1'b0;
        push <= go;
        if (go) begin
          opcode      <= queued_probes[0].op;
          pos_hash    <= queued_probes[0].pos_hash;
          black_word0 <= queued_probes[0].black[0];
          black_word1 <= queued_probes[0].black[1];
          black_word2 <= queued_probes[0].black[2];
          black_word3 <= queued_probes[0].black[3];
          white_word0 <= queued_probes[0].white[0];
          white_word1 <= queued_probes[0].white[1];
          white_word2 <= queued_probes[0].white[2];
          white_word3 <= queued_probes[0].white[3];
        end
      end
    end
  end

  // result side: random pops, a calm stretch and one long hold-off
  always @(posedge clk) begin : result_drain
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) results_taken++;
      if (!hold_done && results_taken >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else if (results_taken >= CALM_FROM && results_taken < CALM_TO) begin
        pop <= 1'b1;
      end else begin
        pop <= $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // checks the popped word, then predicts for the word accepted at this edge
  always @(posedge clk) begin : result_check
    res_t  want;
    item_t seen;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result popped with no word outstanding");
          errors_seen++;
        end else begin
          want = pending_results.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errors_seen++;
          end
          if (newly_filled !== want.newly_filled) begin
            $error("newly_filled: expected %0d, got %0d", want.newly_filled, newly_filled);
            errors_seen++;
          end
          if (occupied_count !== want.occupied_count) begin
            $error("occupied_count: expected %0d, got %0d", want.occupied_count,
                   occupied_count);
            errors_seen++;
          end
        end
      end
      if (push && !full) begin
        seen.op       = opcode;
        seen.pos_hash = pos_hash;
        seen.black[0] = black_word0;
        seen.black[1] = black_word1;
        seen.black[2] = black_word2;
        seen.black[3] = black_word3;
        seen.white[0] = white_word0;
        seen.white[1] = white_word1;
        seen.white[2] = white_word2;
        seen.white[3] = white_word3;
        pending_results = {pending_results, probe_table(seen)};
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin : stall_watch
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL four_way_hashed_position_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] h_all;
    logic [63:0] h_b0[5];
    words_t      zeros;
    words_t      ones;
    words_t      tweak;
    words_t      brd[5];
    logic [63:0] hot_hash[$];
    words_t      black_pool[3];
    words_t      white_pool[3];
    item_t       it;
    logic        op;
    int unsigned sel;
    int unsigned wsel;
    int unsigned bsel;
    int unsigned b0;

    // empty table, counters cleared
    for (int w = 0; w < TABLE_WAYS; w++) shadow_tag[w] = '0;
    shadow_victim = '0;
    shadow_filled = '0;

    zeros = '0;
    ones  = '1;
    h_all = '1;
    b0    = int'(splitmix_mix(64'd0) & (BUCKETS - 1));
    for (int k = 0; k < 5; k++) begin
      h_b0[k] = hash_for_bucket(b0);
      brd[k]  = random_words();
    end

    // directed: empty table, repeats, tag match with a different board
    queue_probe(make_probe(OP_LOOKUP, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_INSERT, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_INSERT, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_INSERT, h_all, ones, ones), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_all, ones, ones), 1'b0);
    tweak = ones;
    tweak[3][0] = 1'b0;
    queue_probe(make_probe(OP_LOOKUP, h_all, ones, tweak), 1'b0);
    queue_probe(make_probe(OP_INSERT, h_all, ones, tweak), 1'b0);
    tweak = ones;
    tweak[0][63] = 1'b0;
    queue_probe(make_probe(OP_LOOKUP, h_all, tweak, ones), 1'b0);

    // directed: fill the bucket of hash zero, then round-robin replacement
    for (int k = 0; k < 3; k++)
      queue_probe(make_probe(OP_INSERT, h_b0[k], brd[k], brd[4 - k]), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_b0[3], brd[3], brd[1]), 1'b0);
    queue_probe(make_probe(OP_INSERT, h_b0[3], brd[3], brd[1]), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_b0[3], brd[3], brd[1]), 1'b0);
    queue_probe(make_probe(OP_INSERT, 64'd0, zeros, zeros), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_b0[0], brd[0], brd[4]), 1'b0);
    queue_probe(make_probe(OP_INSERT, h_b0[4], brd[4], brd[0]), 1'b0);
    queue_probe(make_probe(OP_INSERT, h_b0[1], brd[1], brd[3]), 1'b0);
    // victim counter wrapped on the insert above; this one replaces way zero
    queue_probe(make_probe(OP_INSERT, h_b0[2], brd[2], brd[2]), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_b0[2], brd[2], brd[2]), 1'b0);
    queue_probe(make_probe(OP_LOOKUP, h_b0[1], brd[1], brd[3]), 1'b0);

    // a few crowded buckets and a small board pool, so keys collide often
    for (int i = 0; i < 6; i++) begin
      sel = $urandom_range(BUCKETS - 1);
      for (int j = 0; j < 8; j++) hot_hash = {hot_hash, hash_for_bucket(sel)};
    end
    for (int k = 0; k < 3; k++) begin
      black_pool[k] = random_words();
      white_pool[k] = random_words();
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(99);
      op  = ($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP;
      if (sel < 30) begin
        // a key seen before: hit, or miss once replaced
        it    = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        it.op = op;
      end else if (sel < 65) begin
        it = make_probe(op, hot_hash[$urandom_range(hot_hash.size() - 1)],
                        black_pool[$urandom_range(2)], white_pool[$urandom_range(2)]);
      end else if (sel < 80) begin
        // same hash as a stored key, one stone different
        it    = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        it.op = op;
        wsel  = $urandom_range(2 * WORDS - 1);
        bsel  = $urandom_range(63);
        if (wsel < WORDS) it.black[wsel][bsel] = ~it.black[wsel][bsel];
        else              it.white[wsel - WORDS][bsel] = ~it.white[wsel - WORDS][bsel];
      end else begin
        it = make_probe(op, {$urandom, $urandom}, random_words(), random_words());
      end
      queue_probe(it, n == DRAIN_AT);
    end

    // everything offered and taken, then a short tail for stray results
    while (queued_probes.size() != 0 || push) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors_seen == 0 && pending_results.size() == 0) begin
      $display("PASS four_way_hashed_position_table_top");
    end else begin
      $display("FAIL four_way_hashed_position_table_top");
    end
    $finish;
  end

endmodule

// ----- four_way_hashed_position_table_top.f -----
src/fhpt_pkg.sv
src/fhpt_queue.sv
src/fhpt_front.sv
src/fhpt_back.sv
src/four_way_hashed_position_table_top.sv
tb/tb.sv
